// File: hw/rtl/process_stack_keyed_delete_assert.svh
// Assertion macros for the process stack RTL
`ifndef PROCESS_STACK_KEYED_DELETE_ASSERT_SVH
`define PROCESS_STACK_KEYED_DELETE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PSK_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define PSK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/psk_pkg.sv
// Types and constants for the process stack with keyed delete
package psk_pkg;

    localparam int NAME_W = 64;
    localparam int PRIO_W = 8;
    localparam int PID_W  = 22;
    localparam int RT_W   = 16;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_NAME = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_PID  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Operation the datapath carries out on a commit cycle
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_PUSH = 3'd1,
        OP_FULL = 3'd2,
        OP_TAKE = 3'd3,
        OP_MISS = 3'd4
    } psk_op_t;

    typedef struct packed {
        logic    load;
        psk_op_t op;
    } psk_cmd_t;

    typedef struct packed {
        logic push;
        logic full;
        logic hit;
    } psk_stat_t;

endpackage

// File: hw/rtl/psk_ctrl.sv
// Request sequencer and result valid tracking for the process stack
module psk_ctrl
    import psk_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  psk_stat_t stat,
    output psk_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_RESOLVE = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;

    // Sequence one request: capture, then resolve once the result slot is free
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd.load       = 1'b0;
        cmd.op         = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (out_free) begin
                    if (stat.push) begin
                        cmd.op = stat.full ? OP_FULL : OP_PUSH;
                    end else begin
                        cmd.op = stat.hit ? OP_TAKE : OP_MISS;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/psk_dp.sv
// Record cells, parallel match, compaction and result register for the process stack
`include "process_stack_keyed_delete_assert.svh"

module psk_dp
    import psk_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  psk_cmd_t           cmd,
    output psk_stat_t          stat,
    input  logic [REQ_W-1:0]   s_req_type,
    input  logic [NAME_W-1:0]  s_name_key,
    input  logic [PRIO_W-1:0]  s_prio,
    input  logic [PID_W-1:0]   s_proc_pid,
    input  logic [RT_W-1:0]    s_run_time,
    output logic [STAT_W-1:0]  m_status,
    output logic [NAME_W-1:0]  m_out_name_key,
    output logic [PRIO_W-1:0]  m_out_prio,
    output logic [PID_W-1:0]   m_out_pid,
    output logic [RT_W-1:0]    m_out_run_time
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Record cells, entry 0 at the bottom
    logic [KEY_BITS-1:0] cell_key_reg  [DEPTH];
    logic [PRIO_W-1:0]   cell_prio_reg [DEPTH];
    logic [PID_W-1:0]    cell_pid_reg  [DEPTH];
    logic [RT_W-1:0]     cell_rt_reg   [DEPTH];
    logic [KEY_BITS-1:0] cell_key_next  [DEPTH];
    logic [PRIO_W-1:0]   cell_prio_next [DEPTH];
    logic [PID_W-1:0]    cell_pid_next  [DEPTH];
    logic [RT_W-1:0]     cell_rt_next   [DEPTH];

    logic [CNT_W-1:0]    count_reg, count_next;

    // Captured request
    logic                req_push_reg;
    logic [KEY_BITS-1:0] req_key_reg;
    logic [PRIO_W-1:0]   req_prio_reg;
    logic [PID_W-1:0]    req_pid_reg;
    logic [RT_W-1:0]     req_rt_reg;
    logic [DEPTH-1:0]    match_reg, match_next;

    // Result register
    logic [STAT_W-1:0]   out_status_reg;
    logic [NAME_W-1:0]   out_key_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [PID_W-1:0]    out_pid_reg;
    logic [RT_W-1:0]     out_rt_reg;

    logic [DEPTH-1:0]    rev_match, rev_low_mask, shift_mask, hit_oh;
    logic                any_hit;
    logic [KEY_BITS-1:0] sel_key;
    logic [PRIO_W-1:0]   sel_prio;
    logic [PID_W-1:0]    sel_pid;
    logic [RT_W-1:0]     sel_rt;

    // Compare every valid cell against the incoming request
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) < count_reg) begin
                case (s_req_type)
                    REQ_POP:      match_next[i] = 1'b1;
                    REQ_DEL_NAME: match_next[i] = (cell_key_reg[i] == s_name_key[KEY_BITS-1:0]);
                    REQ_DEL_PID:  match_next[i] = (cell_pid_reg[i] == s_proc_pid);
                    default:      match_next[i] = 1'b0;
                endcase
            end else begin
                match_next[i] = 1'b0;
            end
        end
    end

    // Find the topmost match: reverse, mask up to the lowest set bit with one subtract
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            rev_match[i] = match_reg[DEPTH-1-i];
        end
        rev_low_mask = rev_match ^ (rev_match - DEPTH'(1));
        for (int i = 0; i < DEPTH; i++) begin
            shift_mask[i] = rev_low_mask[DEPTH-1-i] & any_hit;
        end
        hit_oh = match_reg & shift_mask;
    end

    assign any_hit = |match_reg;

    // Gather the removed record through a one-hot select
    always_comb begin
        sel_key  = '0;
        sel_prio = '0;
        sel_pid  = '0;
        sel_rt   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_key  = sel_key  | (cell_key_reg[i]  & {KEY_BITS{hit_oh[i]}});
            sel_prio = sel_prio | (cell_prio_reg[i] & {PRIO_W{hit_oh[i]}});
            sel_pid  = sel_pid  | (cell_pid_reg[i]  & {PID_W{hit_oh[i]}});
            sel_rt   = sel_rt   | (cell_rt_reg[i]   & {RT_W{hit_oh[i]}});
        end
    end

    // Per-cell next value: write on push, take the cell above on removal
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0] up_key;
        logic [PRIO_W-1:0]   up_prio;
        logic [PID_W-1:0]    up_pid;
        logic [RT_W-1:0]     up_rt;
        logic                wr_push, wr_shift;

        if (g < DEPTH - 1) begin : g_up
            assign up_key  = cell_key_reg[g+1];
            assign up_prio = cell_prio_reg[g+1];
            assign up_pid  = cell_pid_reg[g+1];
            assign up_rt   = cell_rt_reg[g+1];
        end else begin : g_top
            assign up_key  = cell_key_reg[g];
            assign up_prio = cell_prio_reg[g];
            assign up_pid  = cell_pid_reg[g];
            assign up_rt   = cell_rt_reg[g];
        end

        assign wr_push  = (cmd.op == OP_PUSH) && (count_reg == CNT_W'(g));
        assign wr_shift = (cmd.op == OP_TAKE) && shift_mask[g];

        assign cell_key_next[g]  = wr_push ? req_key_reg  : (wr_shift ? up_key  : cell_key_reg[g]);
        assign cell_prio_next[g] = wr_push ? req_prio_reg : (wr_shift ? up_prio : cell_prio_reg[g]);
        assign cell_pid_next[g]  = wr_push ? req_pid_reg  : (wr_shift ? up_pid  : cell_pid_reg[g]);
        assign cell_rt_next[g]   = wr_push ? req_rt_reg   : (wr_shift ? up_rt   : cell_rt_reg[g]);
    end

    // Advance the entry count
    always_comb begin
        case (cmd.op)
            OP_PUSH: count_next = count_reg + CNT_W'(1);
            OP_TAKE: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    assign stat.push = req_push_reg;
    assign stat.full = (count_reg == CNT_W'(DEPTH));
    assign stat.hit  = any_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Hold cells and captured request
    always_ff @(posedge aclk) begin
        cell_key_reg  <= cell_key_next;
        cell_prio_reg <= cell_prio_next;
        cell_pid_reg  <= cell_pid_next;
        cell_rt_reg   <= cell_rt_next;
        if (cmd.load) begin
            req_push_reg <= (s_req_type == REQ_PUSH);
            req_key_reg  <= s_name_key[KEY_BITS-1:0];
            req_prio_reg <= s_prio;
            req_pid_reg  <= s_proc_pid;
            req_rt_reg   <= s_run_time;
            match_reg    <= match_next;
        end
    end

    // Load the result beat on commit
    always_ff @(posedge aclk) begin
        if (cmd.op != OP_NONE) begin
            if (cmd.op == OP_TAKE) begin
                out_key_reg  <= NAME_W'(sel_key);
                out_prio_reg <= sel_prio;
                out_pid_reg  <= sel_pid;
                out_rt_reg   <= sel_rt;
            end else begin
                out_key_reg  <= '0;
                out_prio_reg <= '0;
                out_pid_reg  <= '0;
                out_rt_reg   <= '0;
            end
            case (cmd.op)
                OP_PUSH: out_status_reg <= ST_OK;
                OP_TAKE: out_status_reg <= ST_OK;
                OP_FULL: out_status_reg <= ST_FULL;
                default: out_status_reg <= ST_MISS;
            endcase
        end
    end

    assign m_status       = out_status_reg;
    assign m_out_name_key = out_key_reg;
    assign m_out_prio     = out_prio_reg;
    assign m_out_pid      = out_pid_reg;
    assign m_out_run_time = out_rt_reg;

    `PSK_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH),
        "entry count above depth")
    `PSK_ASSERT_SAME(a_take_onehot, cmd.op == OP_TAKE, $onehot(hit_oh),
        "removal without exactly one selected cell")
    `PSK_ASSERT_NEXT(a_take_count, cmd.op == OP_TAKE, count_reg == $past(count_reg) - CNT_W'(1),
        "removal did not decrement the count")
    `PSK_ASSERT_NEXT(a_push_count, cmd.op == OP_PUSH, count_reg == $past(count_reg) + CNT_W'(1),
        "push did not increment the count")

endmodule

// File: hw/rtl/process_stack_keyed_delete.sv
// A result beat is registered when the resolve state that follows the capture of its
// request beat commits. New requests are accepted only in the idle state, so each one
// passes capture-and-match, then resolve-and-compact over the record cell array.
// A stalled result beat holds the resolve cycle until the output slot frees.
// Reset (aresetn, synchronous, active low) empties the stack; cell contents are
// not cleared, since cells at or above the entry count are never read.
module process_stack_keyed_delete
    import psk_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [REQ_W-1:0]   s_req_type,
    input  logic [NAME_W-1:0]  s_name_key,
    input  logic [PRIO_W-1:0]  s_prio,
    input  logic [PID_W-1:0]   s_proc_pid,
    input  logic [RT_W-1:0]    s_run_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [NAME_W-1:0]  m_out_name_key,
    output logic [PRIO_W-1:0]  m_out_prio,
    output logic [PID_W-1:0]   m_out_pid,
    output logic [RT_W-1:0]    m_out_run_time
);

    psk_cmd_t  cmd;
    psk_stat_t stat;

    // Sequencer
    psk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Record cells and result register
    psk_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_name_key     (s_name_key),
        .s_prio         (s_prio),
        .s_proc_pid     (s_proc_pid),
        .s_run_time     (s_run_time),
        .m_status       (m_status),
        .m_out_name_key (m_out_name_key),
        .m_out_prio     (m_out_prio),
        .m_out_pid      (m_out_pid),
        .m_out_run_time (m_out_run_time)
    );

endmodule

// File: sim/tb_process_stack_keyed_delete.sv
// Self-checking testbench for the process record stack with keyed delete
module tb_process_stack_keyed_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import psk_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int KEY_BITS    = 64;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_REQS = 750;
    localparam logic [NAME_W-1:0] KEY_MASK =
        (KEY_BITS >= NAME_W) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [NAME_W-1:0] name;
        logic [PRIO_W-1:0] prio;
        logic [PID_W-1:0]  pid;
        logic [RT_W-1:0]   rt;
        int                gap;
        bit                wait_drain;
    } proc_req_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [NAME_W-1:0] name;
        logic [PRIO_W-1:0] prio;
        logic [PID_W-1:0]  pid;
        logic [RT_W-1:0]   rt;
    } proc_reply_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type = REQ_PUSH;
    logic [NAME_W-1:0] s_name_key = '0;
    logic [PRIO_W-1:0] s_prio = '0;
    logic [PID_W-1:0]  s_proc_pid = '0;
    logic [RT_W-1:0]   s_run_time = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [NAME_W-1:0] m_out_name_key;
    logic [PRIO_W-1:0] m_out_prio;
    logic [PID_W-1:0]  m_out_pid;
    logic [RT_W-1:0]   m_out_run_time;

    proc_req_t   pending_reqs[$];
    proc_reply_t expected_replies[$];

    // Shadow copy of the record stack, entry 0 at the bottom
    logic [NAME_W-1:0] name_cells[STACK_DEPTH];
    logic [PRIO_W-1:0] prio_cells[STACK_DEPTH];
    logic [PID_W-1:0]  pid_cells[STACK_DEPTH];
    logic [RT_W-1:0]   rt_cells[STACK_DEPTH];
    int                stack_fill = 0;

    int  reqs_taken = 0;
    int  replies_taken = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  gap_left = -1;
    int  stall_left = 0;
    bit  rx_burst = 1'b0;
    bit  send_burst = 1'b0;
    bit  took_req;
    bit  took_reply;
    proc_req_t   next_req;
    proc_req_t   seen_req;
    proc_reply_t want;

    logic [NAME_W-1:0] name_pool[8];
    logic [PID_W-1:0]  pid_pool[8];

    process_stack_keyed_delete #(
        .DEPTH   (STACK_DEPTH),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_name_key    (s_name_key),
        .s_prio        (s_prio),
        .s_proc_pid    (s_proc_pid),
        .s_run_time    (s_run_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_name_key(m_out_name_key),
        .m_out_prio    (m_out_prio),
        .m_out_pid     (m_out_pid),
        .m_out_run_time(m_out_run_time)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Apply one request to the shadow stack and return the reply it causes
    function automatic proc_reply_t apply_to_stack(input proc_req_t r);
        proc_reply_t rep;
        int hit_at;
        rep = '{status: ST_MISS, name: '0, prio: '0, pid: '0, rt: '0};
        hit_at = -1;
        case (r.kind)
            REQ_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    name_cells[stack_fill] = r.name & KEY_MASK;
                    prio_cells[stack_fill] = r.prio;
                    pid_cells[stack_fill]  = r.pid;
                    rt_cells[stack_fill]   = r.rt;
                    stack_fill++;
                    rep.status = ST_OK;
                end
            end
            REQ_POP: begin
                if (stack_fill > 0) hit_at = stack_fill - 1;
            end
            REQ_DEL_NAME: begin
                for (int i = stack_fill - 1; i >= 0 && hit_at < 0; i--)
                    if (name_cells[i] == (r.name & KEY_MASK)) hit_at = i;
            end
            default: begin
                for (int i = stack_fill - 1; i >= 0 && hit_at < 0; i--)
                    if (pid_cells[i] == r.pid) hit_at = i;
            end
        endcase
        // Hand back the removed record and close the gap above it
        if (hit_at >= 0) begin
            rep.status = ST_OK;
            rep.name   = name_cells[hit_at];
            rep.prio   = prio_cells[hit_at];
            rep.pid    = pid_cells[hit_at];
            rep.rt     = rt_cells[hit_at];
            for (int i = hit_at; i + 1 < stack_fill; i++) begin
                name_cells[i] = name_cells[i + 1];
                prio_cells[i] = prio_cells[i + 1];
                pid_cells[i]  = pid_cells[i + 1];
                rt_cells[i]   = rt_cells[i + 1];
            end
            stack_fill--;
        end
        return rep;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] reply beat %0d: %s got %h want %h",
                     $realtime, replies_taken, field, got, exp_val);
    endtask

    task automatic add_req(input logic [REQ_W-1:0] kind, input logic [NAME_W-1:0] name,
                           input logic [PRIO_W-1:0] prio, input logic [PID_W-1:0] pid,
                           input logic [RT_W-1:0] rt, input bit wait_drain);
        proc_req_t r;
        r.kind       = kind;
        r.name       = name;
        r.prio       = prio;
        r.pid        = pid;
        r.rt         = rt;
        r.gap        = send_burst ? 0 : $urandom_range(0, 11);
        r.wait_drain = wait_drain;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [NAME_W-1:0] pick_name();
        if ($urandom_range(0, 7) == 0) return {$urandom(), $urandom()};
        return name_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [PID_W-1:0] pick_pid();
        if ($urandom_range(0, 7) == 0) return PID_W'($urandom_range(0, 22'h3FFFFF));
        return pid_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        return PRIO_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [RT_W-1:0] pick_rt();
        return RT_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Build the request list, then wait for every reply and judge the run
    initial begin
        int done_reqs;
        int phase_len;
        int push_pct;
        int phase_idx;
        int roll;
        logic [NAME_W-1:0] key_a;
        logic [NAME_W-1:0] key_b;

        for (int i = 0; i < 8; i++) begin
            name_pool[i] = {$urandom(), $urandom()};
            pid_pool[i]  = PID_W'($urandom_range(0, 22'h3FFFFF));
        end
        key_a = name_pool[0];
        key_b = name_pool[1];

        // Directed: empty store, field extremes, duplicates, compaction, misses
        add_req(REQ_POP,      '0, '0, '0, '0, 1'b0);
        add_req(REQ_DEL_NAME, '0, '0, '0, '0, 1'b0);
        add_req(REQ_DEL_PID,  '0, '0, '0, '0, 1'b0);
        add_req(REQ_PUSH, '0, '0, '0, '0, 1'b0);
        add_req(REQ_PUSH, '1, '1, '1, '1, 1'b0);
        add_req(REQ_PUSH, key_a, 8'h11, pid_pool[0], 16'h1111, 1'b0);
        add_req(REQ_PUSH, key_b, 8'h22, pid_pool[1], 16'h2222, 1'b0);
        add_req(REQ_PUSH, key_a, 8'h33, pid_pool[2], 16'h3333, 1'b0);
        add_req(REQ_DEL_NAME, key_a, '0, '0, '0, 1'b1);
        add_req(REQ_DEL_NAME, key_a ^ 64'h8000_0000_0000_0000, '0, '0, '0, 1'b0);
        add_req(REQ_DEL_PID, '0, '0, pid_pool[3] ^ 22'h200000, '0, 1'b0);
        add_req(REQ_DEL_PID, '0, '0, pid_pool[0], '0, 1'b0);
        add_req(REQ_DEL_PID, '0, '0, '1, '0, 1'b0);
        add_req(REQ_POP, '0, '0, '0, '0, 1'b0);
        add_req(REQ_DEL_NAME, '0, '0, '0, '0, 1'b0);
        add_req(REQ_POP, '0, '0, '0, '0, 1'b0);
        add_req(REQ_POP, '0, '0, '0, '0, 1'b0);

        // Random: alternate fill, mixed and drain phases so full and empty recur
        done_reqs = 0;
        phase_idx = 0;
        while (done_reqs < RANDOM_REQS) begin
            send_burst = ($urandom_range(0, 3) == 0);
            case (phase_idx % 3)
                0: begin push_pct = 90; phase_len = $urandom_range(90, 110); end
                1: begin push_pct = 50; phase_len = $urandom_range(60, 100); end
                default: begin push_pct = 15; phase_len = $urandom_range(80, 100); end
            endcase
            for (int n = 0; n < phase_len; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct) begin
                    add_req(REQ_PUSH, pick_name(), pick_prio(), pick_pid(),
                            pick_rt(), (n == 0));
                end else begin
                    roll = $urandom_range(0, 9);
                    if (roll < 4)
                        add_req(REQ_POP, pick_name(), pick_prio(), pick_pid(),
                                pick_rt(), ($urandom_range(0, 59) == 0));
                    else if (roll < 7)
                        add_req(REQ_DEL_NAME, pick_name(), pick_prio(),
                                pick_pid(), pick_rt(), 1'b0);
                    else
                        add_req(REQ_DEL_PID, pick_name(), pick_prio(),
                                pick_pid(), pick_rt(), 1'b0);
                end
            end
            done_reqs += phase_len;
            phase_idx++;
        end

        while (!aresetn) @(posedge aclk);
        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Request driver: hold a beat until accepted, then pause or present the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = -1;
        end else if (!s_valid || s_ready) begin
            took_req   = s_valid && s_ready;
            took_reply = m_valid && m_ready;
            if (pending_reqs.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                if (gap_left < 0) gap_left = pending_reqs[0].gap;
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs[0].wait_drain &&
                             (reqs_taken + took_req != replies_taken + took_reply)) begin
                    s_valid <= 1'b0;
                end else begin
                    next_req = pending_reqs.pop_front();
                    s_req_type <= next_req.kind;
                    s_name_key <= next_req.name;
                    s_prio     <= next_req.prio;
                    s_proc_pid <= next_req.pid;
                    s_run_time <= next_req.rt;
                    s_valid    <= 1'b1;
                    gap_left = -1;
                end
            end
        end
    end

    // Monitor: predict on each request beat, check each reply beat, pace m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                seen_req = '{kind: s_req_type, name: s_name_key, prio: s_prio,
                             pid: s_proc_pid, rt: s_run_time, gap: 0, wait_drain: 1'b0};
                expected_replies.push_back(apply_to_stack(seen_req));
                reqs_taken <= reqs_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected beat, status", 64'(m_status), '0);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 64'(m_status), 64'(want.status));
                    if (m_out_name_key !== want.name)
                        report_mismatch("name_key", m_out_name_key, want.name);
                    if (m_out_prio !== want.prio)
                        report_mismatch("prio", 64'(m_out_prio), 64'(want.prio));
                    if (m_out_pid !== want.pid)
                        report_mismatch("pid", 64'(m_out_pid), 64'(want.pid));
                    if (m_out_run_time !== want.rt)
                        report_mismatch("run_time", 64'(m_out_run_time), 64'(want.rt));
                end
                replies_taken <= replies_taken + 1;
                if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
